@@ rtl/pbmsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmsa_pkg
// Shared constants, item types and state encoding of the per-bin accumulator.
// ----------------------------------------------------------------------------
package pbmsa_pkg;

    localparam int NUM_CHANNELS = 64;
    localparam int MAX_WINDOW   = 32768;
    localparam int COUNT_BITS   = 16;

    localparam int OFF_W   = 15;
    localparam int CH_W    = 6;
    localparam int SMP_W   = 12;
    localparam int WL_W    = 16;
    localparam int CNTO_W  = 16;
    localparam int MEAN_W  = 14;
    localparam int STD_W   = 13;
    localparam int BIN_W   = CH_W + OFF_W;
    localparam int CMEM_W  = $clog2(MAX_WINDOW);

    localparam int VSUM_W  = 28;
    localparam int SQSUM_W = 39;
    localparam int SQLO_W  = 20;
    localparam int DLO_W   = 28;

    localparam int BASE_OFFSET = 2048;
    localparam int SCALE_NUM   = 341;
    localparam int SCALE_SQ    = SCALE_NUM * SCALE_NUM;
    localparam int SCALE_SH    = 7;
    localparam int OUT_LIMIT   = 5456;
    localparam int WL_RESET    = 32768;

    localparam int SNUM_W  = 9;
    localparam int SSQ_W   = 17;
    localparam int DEN_W   = COUNT_BITS + SCALE_SH;
    localparam int NUM_W   = VSUM_W + SNUM_W;
    localparam int PROD_W  = COUNT_BITS + SQSUM_W;
    localparam int RAD_W   = PROD_W + SSQ_W;
    localparam int ROOT_W  = (RAD_W + 1) / 2;
    localparam int DIV_W   = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [OFF_W-1:0]  offset;
        logic [CH_W-1:0]   channel;
        logic [SMP_W-1:0]  sample_value;
        logic              end_of_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_value;
        logic [STD_W-1:0]         std_value;
        logic [CNTO_W-1:0]        window_count;
        logic                     empty_bin;
        logic                     rejected;
    } t_out_item;

    typedef struct packed {
        logic [VSUM_W-1:0]  vsum;
        logic [SQSUM_W-1:0] sqsum;
    } t_bin;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL1, S_MUL2, S_MUL3, S_MUL4,
        S_DIVM, S_SQRT, S_DIVS, S_DONE
    } t_state;

endpackage

@@ rtl/pbmsa_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmsa_in_if
// Input channel: valid/ready handshake carrying one input item.
// ----------------------------------------------------------------------------
interface pbmsa_in_if;
    import pbmsa_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/pbmsa_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmsa_out_if
// Output channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface pbmsa_out_if;
    import pbmsa_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/per_bin_mean_std_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_bin_mean_std_accumulator
// Per (channel, offset) sum and sum-of-squares store with mean/std readout.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An accumulate item, a readout of an
// empty bin or an item refused for a saturated count passes accept,
// memory read, modify and write back, and result, in that order, set by
// the read-modify-write of the single bin memory. An item refused for its
// offset skips the memory and goes from accept to result. A readout of a
// non-empty bin passes four multiply stages, then one shared bit-serial
// divider for the mean, a bit-serial square root and the divider
// again for the deviation. A result that is not taken holds the next
// item back. After reset a clearing pass zeroes the bin and count
// memories; no item is accepted during it, window_length writes are taken.
// ----------------------------------------------------------------------------
module per_bin_mean_std_accumulator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pbmsa_pkg::WL_W-1:0]  i_cfg_wdata,
    pbmsa_in_if.sink                    i_in,
    pbmsa_out_if.source                 o_out
);
    import pbmsa_pkg::*;

    // memories
    t_bin                  bin_mem [2**BIN_W];
    logic [COUNT_BITS-1:0] cnt_mem [2**CMEM_W];

    t_state                r_state, n_state;
    logic [WL_W-1:0]       r_wl;
    logic [BIN_W-1:0]      r_clr;
    t_in_item              r_item;
    t_bin                  r_rd_bin;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic                       r_neg;
    logic [NUM_W-1:0]           r_num;
    logic [PROD_W-1:0]          r_plo, r_phi, r_sq;
    logic [PROD_W-1:0]          r_d;
    logic [RAD_W-1:0]           r_dlo, r_dhi, r_rad;
    logic [DEN_W-1:0]           r_den;
    logic [DIV_W-1:0]           r_m;

    logic                  w_in_bad;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_in_ready;
    logic                  w_rd_en;
    logic                  w_bin_we;
    logic                  w_cnt_we;
    logic                  w_div_start;
    logic                  w_sqrt_start;
    logic                  w_out_load;
    logic [BIN_W-1:0]      w_bin_addr;
    logic [BIN_W-1:0]      w_wr_addr;
    t_bin                  w_wr_bin;
    logic [CMEM_W-1:0]     w_cnt_addr;
    logic [COUNT_BITS-1:0] w_wr_cnt;
    logic                  w_sat;
    logic [DIV_W-1:0]      w_div_in;
    logic                  w_div_done, w_sqrt_done;
    logic [DIV_W-1:0]      w_quo;
    logic [ROOT_W-1:0]     w_root;
    logic signed [SMP_W:0] w_v;
    logic [2*SMP_W+1:0]    w_vsq;
    logic [VSUM_W-1:0]     w_mag;
    logic [DIV_W-1:0]      w_q_sat;

    assign w_in_bad = ({1'b0, i_in.payload.offset} >= r_wl)
                   || (int'(i_in.payload.offset) >= MAX_WINDOW)
                   || (int'(i_in.payload.channel) >= NUM_CHANNELS);
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_bin_addr = {r_item.channel, r_item.offset};
    assign w_sat      = (r_rd_cnt == '1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in.valid) n_state = w_in_bad ? S_DONE : S_READ;
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (r_item.action == ACT_READ && r_rd_cnt != '0) n_state = S_MUL1;
                else n_state = S_DONE;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_MUL4;
            S_MUL4: n_state = S_DIVM;
            S_DIVM: if (w_div_done) n_state = S_SQRT;
            S_SQRT: if (w_sqrt_done) n_state = S_DIVS;
            S_DIVS: if (w_div_done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready   = 1'b0;
        w_rd_en      = 1'b0;
        w_bin_we     = 1'b0;
        w_cnt_we     = 1'b0;
        w_div_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_out_load   = 1'b0;
        w_div_in     = DIV_W'(r_num);
        case (r_state)
            S_CLEAR: begin
                w_bin_we = 1'b1;
                w_cnt_we = 1'b1;
            end
            S_IDLE: w_in_ready = 1'b1;
            S_READ: w_rd_en = 1'b1;
            S_EXEC: begin
                w_bin_we = (r_item.action == ACT_ACCUM) && !w_sat;
                w_cnt_we = (r_item.action == ACT_ACCUM) && !w_sat && r_item.end_of_sample;
            end
            S_MUL4: w_div_start = 1'b1;
            S_DIVM: w_sqrt_start = w_div_done;
            S_SQRT: begin
                w_div_start = w_sqrt_done;
                w_div_in    = DIV_W'(w_root);
            end
            S_DONE: w_out_load = w_out_free;
            default: ;
        endcase
    end

    // accumulate update
    assign w_v   = signed'({1'b0, r_item.sample_value}) - (SMP_W + 1)'(BASE_OFFSET);
    assign w_vsq = (2*SMP_W + 2)'(w_v * w_v);
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_wr_addr  = r_clr;
            w_wr_bin   = '0;
            w_cnt_addr = r_clr[CMEM_W-1:0];
            w_wr_cnt   = '0;
        end else begin
            w_wr_addr      = w_bin_addr;
            w_wr_bin.vsum  = r_rd_bin.vsum + VSUM_W'(w_v);
            w_wr_bin.sqsum = r_rd_bin.sqsum + SQSUM_W'(w_vsq);
            w_cnt_addr     = r_item.offset[CMEM_W-1:0];
            w_wr_cnt       = r_rd_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bin_we) bin_mem[w_wr_addr] <= w_wr_bin;
        if (w_cnt_we) cnt_mem[w_cnt_addr] <= w_wr_cnt;
        if (w_rd_en) begin
            r_rd_bin <= bin_mem[w_bin_addr];
            r_rd_cnt <= cnt_mem[r_item.offset[CMEM_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wl        <= WL_W'(WL_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) r_wl <= i_cfg_wdata;
            if (w_out_load) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    assign w_mag   = r_rd_bin.vsum[VSUM_W-1] ? (~r_rd_bin.vsum + 1'b1) : r_rd_bin.vsum;
    assign w_q_sat = (w_quo > DIV_W'(OUT_LIMIT)) ? DIV_W'(OUT_LIMIT) : w_quo;

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in.payload;
            r_res  <= '{mean_value: '0, std_value: '0, window_count: '0,
                        empty_bin: 1'b0, rejected: w_in_bad};
        end
        case (r_state)
            S_EXEC: begin
                if (r_item.action == ACT_ACCUM && !w_sat && r_item.end_of_sample)
                    r_res.window_count <= CNTO_W'(w_wr_cnt);
                else
                    r_res.window_count <= CNTO_W'(r_rd_cnt);
                if (r_item.action == ACT_ACCUM) begin
                    if (w_sat) r_res.rejected <= 1'b1;
                end else if (r_rd_cnt == '0) begin
                    r_res.empty_bin <= 1'b1;
                end
            end
            S_MUL1: begin
                r_neg <= r_rd_bin.vsum[VSUM_W-1];
                r_num <= NUM_W'(w_mag) * NUM_W'(SCALE_NUM);
                r_sq  <= PROD_W'(w_mag) * PROD_W'(w_mag);
                r_plo <= PROD_W'(r_rd_cnt) * PROD_W'(r_rd_bin.sqsum[SQLO_W-1:0]);
                r_phi <= PROD_W'(r_rd_cnt) * PROD_W'(r_rd_bin.sqsum[SQSUM_W-1:SQLO_W]);
                r_den <= {r_rd_cnt, SCALE_SH'(0)};
            end
            S_MUL2: begin
                // negative variance reads as zero
                if ((r_plo + (r_phi << SQLO_W)) > r_sq)
                    r_d <= r_plo + (r_phi << SQLO_W) - r_sq;
                else
                    r_d <= '0;
            end
            S_MUL3: begin
                r_dlo <= RAD_W'(r_d[DLO_W-1:0]) * RAD_W'(SCALE_SQ);
                r_dhi <= RAD_W'(r_d[PROD_W-1:DLO_W]) * RAD_W'(SCALE_SQ);
            end
            S_MUL4: r_rad <= r_dlo + (r_dhi << DLO_W);
            S_DIVM: if (w_div_done) r_m <= w_q_sat;
            S_DIVS: begin
                if (w_div_done) begin
                    r_res.mean_value <= r_neg ? MEAN_W'(~r_m + 1'b1) : MEAN_W'(r_m);
                    r_res.std_value  <= STD_W'(w_q_sat);
                end
            end
            default: ;
        endcase
        if (w_out_load) r_out <= r_res;
    end

    pbmsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    pbmsa_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (r_rad),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`ifndef SYNTHESIS
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.rejected |->
            o_out.payload.mean_value == '0 && o_out.payload.std_value == '0
            && !o_out.payload.empty_bin)
        else $error("rejected item carries nonzero statistics");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.empty_bin |->
            o_out.payload.window_count == '0 && o_out.payload.std_value == '0
            && o_out.payload.mean_value == '0)
        else $error("empty bin with nonzero fields");

    a_std_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.payload.std_value <= STD_W'(OUT_LIMIT))
        else $error("std beyond saturation limit");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_div_done && !w_sqrt_done)
        else $error("arithmetic unit finished while idle");
`endif

endmodule

@@ rtl/pbmsa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmsa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbmsa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pbmsa_pkg::DIV_W-1:0]    i_dividend,
    input  logic [pbmsa_pkg::DEN_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [pbmsa_pkg::DIV_W-1:0]    o_quotient
);
    import pbmsa_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_dvs;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_quo[DIV_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the top bit drops out
            r_rem <= w_ge ? DEN_W'(w_sh - {1'b0, r_dvs}) : DEN_W'(w_sh);
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/pbmsa_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmsa_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pbmsa_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pbmsa_pkg::RAD_W-1:0]    i_radicand,
    output logic                           o_done,
    output logic [pbmsa_pkg::ROOT_W-1:0]   o_root
);
    import pbmsa_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;
    localparam int PAD_W = 2 * ROOT_W;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [PAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  w_sh;
    logic [REM_W+1:0]  w_trial;
    logic              w_ge;

    assign w_sh    = {r_rem, r_rad[PAD_W-1 -: 2]};
    assign w_trial = (REM_W + 2)'({r_root, 2'b01});
    assign w_ge    = (w_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= PAD_W'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[PAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? REM_W'(w_sh - w_trial) : REM_W'(w_sh);
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ test/per_bin_mean_std_accumulator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_bin_mean_std_accumulator_test
// Self-checking bench: a directed table, window length settings and random
// sample streams with readouts. Every result is checked, against the table
// where a row gives it and else against an in-bench model of the bin store.
// ----------------------------------------------------------------------------
module per_bin_mean_std_accumulator_test;
    import pbmsa_pkg::*;

    localparam int  PERIOD      = 20;
    localparam int  READ_LAT    = 160;
    localparam longint LIMIT    = 8_000_000;
    localparam logic [CNTO_W-1:0] CNT_SAT = CNTO_W'((1 << COUNT_BITS) - 1);

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [WL_W-1:0]   i_cfg_wdata;

    pbmsa_in_if  in_ch ();
    pbmsa_out_if out_ch ();

    per_bin_mean_std_accumulator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // model of the bin store, sparse
    logic [VSUM_W-1:0]  value_sum_of [int];
    logic [SQSUM_W-1:0] square_sum_of [int];
    int unsigned        count_of [int];
    int unsigned        window_len;

    t_out_item bin_results_q [$];
    int        n_errors;
    int        n_items;
    int        n_results;
    int        n_reads;
    int        n_rejects;
    longint    cycle_cnt;
    bit        send_gaps;
    bit        recv_gaps;
    int        hold_left;

    typedef struct {
        int act, off, ch, smp, eos;
        bit typed;
        int mean, sd, cnt, emp, rej;
    } t_row;

    // expected results only where they are plain from the model
    t_row dir_rows [14] = '{
        '{1, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0},
        '{0, 0, 0, 4095, 0, 1, 0, 0, 0, 0, 0},
        '{0, 0, 63, 0, 1, 1, 0, 0, 1, 0, 0},
        '{0, 32767, 63, 2048, 1, 1, 0, 0, 1, 0, 0},
        '{1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
        '{1, 0, 63, 4095, 0, 0, 0, 0, 0, 0, 0},
        '{1, 32767, 63, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 100, 5, 2047, 1, 1, 0, 0, 1, 0, 0},
        '{0, 100, 5, 2049, 1, 1, 0, 0, 2, 0, 0},
        '{1, 100, 5, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 200, 1, 0, 0, 1, 0, 0, 0, 1, 0},
        '{0, 'h5555, 'h2a, 'haaa, 1, 1, 0, 0, 1, 0, 0},
        '{0, 'h2aaa, 'h15, 'h555, 0, 1, 0, 0, 0, 0, 0},
        '{1, 'h2aaa, 'h15, 0, 0, 1, 0, 0, 0, 1, 0}
    };

    function automatic t_out_item predict_bin(t_in_item it);
        t_out_item    r;
        int           key;
        int unsigned  n;
        longint       v;
        longint       sx;
        logic [127:0] mag, m, sq, prod, d, den, q, t, lhs, rhs;
        r = '0;
        if (it.offset >= window_len || it.offset >= MAX_WINDOW
                || it.channel >= NUM_CHANNELS) begin
            r.rejected = 1'b1;
            return r;
        end
        key = it.channel * MAX_WINDOW + it.offset;
        n = count_of.exists(it.offset) ? count_of[it.offset] : 0;
        if (!value_sum_of.exists(key)) begin
            value_sum_of[key]  = '0;
            square_sum_of[key] = '0;
        end
        if (it.action == ACT_ACCUM) begin
            if (n >= CNT_SAT) begin
                r.window_count = n[CNTO_W-1:0];
                r.rejected = 1'b1;
                return r;
            end
            v = longint'(it.sample_value) - BASE_OFFSET;
            value_sum_of[key]  = value_sum_of[key] + v[VSUM_W-1:0];
            square_sum_of[key] = square_sum_of[key] + SQSUM_W'(v * v);
            if (it.end_of_sample) begin
                n++;
                count_of[it.offset] = n;
            end
            r.window_count = n[CNTO_W-1:0];
            return r;
        end
        r.window_count = n[CNTO_W-1:0];
        if (n == 0) begin
            r.empty_bin = 1'b1;
            return r;
        end
        sx   = longint'(signed'(value_sum_of[key]));
        mag  = (sx < 0) ? -sx : sx;
        den  = 128'(n) * 128;
        m    = mag * SCALE_NUM / den;
        if (m > OUT_LIMIT) m = OUT_LIMIT;
        r.mean_value = (sx < 0) ? -m[MEAN_W-1:0] : m[MEAN_W-1:0];
        sq   = mag * mag;
        prod = 128'(n) * square_sum_of[key];
        d    = (prod > sq) ? prod - sq : '0;
        rhs  = d * SCALE_SQ;
        q    = '0;
        for (int b = 12; b >= 0; b--) begin
            t   = q | (128'(1) << b);
            lhs = (t * den) * (t * den);
            if (lhs <= rhs) q = t;
        end
        if (q > OUT_LIMIT) q = OUT_LIMIT;
        r.std_value = q[STD_W-1:0];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #(PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                out_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            n_results++;
            if (bin_results_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = bin_results_q.pop_front();
                if (got !== exp_r) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: mean %0d/%0d std %0d/%0d cnt %0d/%0d "
                                 , exp_r.mean_value, got.mean_value, exp_r.std_value,
                                 got.std_value, exp_r.window_count, got.window_count,
                                 "empty %0b/%0b rej %0b/%0b (exp/got)",
                                 exp_r.empty_bin, got.empty_bin,
                                 exp_r.rejected, got.rejected);
                end
            end
        end
    end

    task automatic send_item(t_in_item it, bit typed, t_out_item typed_r);
        t_out_item r;
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        r = predict_bin(it);
        bin_results_q.push_back(typed ? typed_r : r);
        n_items++;
        if (it.action == ACT_READ) n_reads++;
        if (r.rejected) n_rejects++;
        @(negedge i_clk);
    endtask

    task automatic send_fields(int act, int off, int ch, int smp, int eos);
        t_in_item it;
        it.action        = act[0];
        it.offset        = off[OFF_W-1:0];
        it.channel       = ch[CH_W-1:0];
        it.sample_value  = smp[SMP_W-1:0];
        it.end_of_sample = eos[0];
        send_item(it, 1'b0, '0);
    endtask

    // only while nothing is in flight
    task automatic set_window_length(int unsigned wl);
        in_ch.valid <= 1'b0;
        while (bin_results_q.size() != 0) @(posedge i_clk);
        repeat (READ_LAT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wl[WL_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        window_len = wl;
    endtask

    // mostly whole samples across channels, with readouts and some noise
    task automatic random_stream(int n_target, int off_hi, int ch_hi);
        int start;
        int off, nch;
        start = n_items;
        while (n_items - start < n_target) begin
            case ($urandom_range(0, 9))
                0, 1: send_fields(1, $urandom_range(0, off_hi), $urandom_range(0, ch_hi),
                                  $urandom, $urandom_range(0, 1));
                2: send_fields($urandom_range(0, 1), $urandom_range(0, 32767),
                               $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
                default: begin
                    off = $urandom_range(0, off_hi);
                    nch = $urandom_range(1, ch_hi + 1);
                    for (int c = 0; c < nch; c++)
                        send_fields(0, off, c, $urandom_range(1500, 2600) ^
                                    ($urandom_range(0, 15) == 0 ? $urandom : 0),
                                    c == nch - 1);
                end
            endcase
        end
    endtask

    initial begin
        t_in_item  it;
        t_out_item er;
        cycle_cnt    = 0;
        n_errors     = 0;
        n_items      = 0;
        n_results    = 0;
        n_reads      = 0;
        n_rejects    = 0;
        hold_left    = 0;
        send_gaps    = 1'b1;
        recv_gaps    = 1'b1;
        window_len   = WL_RESET;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            it.action        = dir_rows[k].act[0];
            it.offset        = dir_rows[k].off[OFF_W-1:0];
            it.channel       = dir_rows[k].ch[CH_W-1:0];
            it.sample_value  = dir_rows[k].smp[SMP_W-1:0];
            it.end_of_sample = dir_rows[k].eos[0];
            er.mean_value    = dir_rows[k].mean[MEAN_W-1:0];
            er.std_value     = dir_rows[k].sd[STD_W-1:0];
            er.window_count  = dir_rows[k].cnt[CNTO_W-1:0];
            er.empty_bin     = dir_rows[k].emp[0];
            er.rejected      = dir_rows[k].rej[0];
            send_item(it, dir_rows[k].typed, er);
        end

        // one-sample window, then a zero window that refuses everything
        set_window_length(1);
        send_fields(0, 1, 3, 100, 1);
        send_fields(0, 0, 3, 4000, 1);
        send_fields(1, 0, 3, 0, 0);
        send_fields(1, 1, 0, 0, 0);
        set_window_length(0);
        send_fields(0, 0, 0, 10, 1);
        send_fields(1, 0, 0, 0, 0);

        set_window_length(20);
        random_stream(300, 23, 7);
        hold_left = 400;
        repeat (40) send_fields(0, $urandom_range(0, 19), $urandom_range(0, 63), $urandom, 1);
        random_stream(350, 23, 15);

        set_window_length(65535);
        random_stream(150, 32767, 3);
        for (int k = 0; k < 30; k++) begin
            send_fields(0, 32767 - k, 63, $urandom, 1);
            send_fields(1, 32767 - k, 63, 0, 0);
        end

        set_window_length($urandom_range(2, 12));
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        random_stream(150, 14, 5);

        in_ch.valid <= 1'b0;
        while (bin_results_q.size() != 0) @(posedge i_clk);
        repeat (READ_LAT) @(posedge i_clk);
        if (bin_results_q.size() != 0) n_errors++;

        $display("%0d items sent (%0d readouts, %0d refused), %0d results checked",
                 n_items, n_reads, n_rejects, n_results);
        $display("window lengths 0, 1, 20, 32768, 65535 and one small random setting");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ per_bin_mean_std_accumulator.f @@
rtl/pbmsa_pkg.sv
rtl/pbmsa_in_if.sv
rtl/pbmsa_out_if.sv
rtl/pbmsa_div.sv
rtl/pbmsa_sqrt.sv
rtl/per_bin_mean_std_accumulator.sv
test/per_bin_mean_std_accumulator_test.sv
